### rtl/kum_pkg.sv
// ----------------------------------------------------------------------------
// kum_pkg
// Shared constants and types of the spanning tree unit.
// ----------------------------------------------------------------------------
package kum_pkg;

  localparam int NodeBits     = 10;
  localparam int WeightWidth  = 16;
  localparam int CostWidth    = 26;
  localparam int CountWidth   = 11;
  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 11;
  localparam int InDataWidth  = 40;
  localparam int OutDataWidth = 40;
  localparam int QueueDepth   = 4;

  localparam int DefNodes      = 1024;
  localparam int DefWeightBits = 16;

  localparam logic [CountWidth-1:0] GoalReset = 11'd1023;

  // register indexes of the configuration port
  localparam logic [CfgIdxWidth-1:0] RegEdgeGoal   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegSkipEnable = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegSkipNode   = 2'd2;

  // classified edge handed from front to back
  typedef struct packed {
    logic [NodeBits-1:0]    end_a;
    logic [NodeBits-1:0]    end_b;
    logic [WeightWidth-1:0] weight;
    logic                   restart;
    logic                   ignore;
  } cmd_t;

endpackage

### rtl/kum_front.sv
// ----------------------------------------------------------------------------
// kum_front
// Accepts edges, masks the weight and flags skipped or out-of-range edges.
// ----------------------------------------------------------------------------
module kum_front
  import kum_pkg::*;
#(
  parameter int NODES       = DefNodes,
  parameter int WEIGHT_BITS = DefWeightBits
) (
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // end_a[9:0], end_b[19:10], weight[35:20], restart[36], zero fill
  input  logic [InDataWidth-1:0] s_axis_tdata,
  input  logic                   skip_en_i,
  input  logic [NodeBits-1:0]    skip_node_i,
  input  logic                   busy_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output cmd_t                   q_cmd_o
);

  localparam logic [WeightWidth-1:0] WMask = (WEIGHT_BITS >= WeightWidth) ?
      {WeightWidth{1'b1}} : WeightWidth'((64'd1 << WEIGHT_BITS) - 64'd1);

  logic [NodeBits-1:0] a, b;
  logic                out_of_range, skipped;

  assign a = s_axis_tdata[NodeBits-1:0];
  assign b = s_axis_tdata[2*NodeBits-1:NodeBits];

  // classification of the edge
  assign out_of_range = (32'(a) >= NODES) || (32'(b) >= NODES);
  assign skipped      = skip_en_i && (b == skip_node_i);

  assign q_cmd_o.end_a   = a;
  assign q_cmd_o.end_b   = b;
  assign q_cmd_o.weight  = s_axis_tdata[2*NodeBits+WeightWidth-1:2*NodeBits] & WMask;
  assign q_cmd_o.restart = s_axis_tdata[2*NodeBits+WeightWidth];
  assign q_cmd_o.ignore  = out_of_range || skipped;

  assign s_axis_tready = !q_full_i && !busy_i;
  assign q_push_o      = s_axis_tvalid && s_axis_tready;

endmodule

### rtl/kum_queue.sv
// ----------------------------------------------------------------------------
// kum_queue
// Short queue of classified edges between front and back.
// ----------------------------------------------------------------------------
module kum_queue
  import kum_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PtrW = $clog2(QueueDepth);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

### rtl/kum_back.sv
// ----------------------------------------------------------------------------
// kum_back
// Union-find sequencer: root walks, path compression, union by size, totals.
// ----------------------------------------------------------------------------
module kum_back
  import kum_pkg::*;
#(
  parameter int NODES = DefNodes
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [CountWidth-1:0]   edge_goal_i,
  input  logic                    q_empty_i,
  input  cmd_t                    q_cmd_i,
  output logic                    q_pop_o,
  output logic                    busy_o,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // taken[0], total_cost[26:1], edges_taken[37:27], complete[38], zero fill
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SW = NW + 1;
  localparam logic [NW-1:0] LastIdx = NW'(NODES - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EVAL, ST_FRD, ST_FCHK, ST_CRD, ST_CCHK,
    ST_SZA, ST_SZB, ST_SZC
  } state_e;

  state_e              state_q;
  cmd_t                cmd_q;
  logic [NW-1:0]       r_q, x_q, ra_q, clr_q;
  logic [SW-1:0]       sa_q;
  logic                side_q, resume_q;
  logic [CostWidth-1:0]  cost_q, cost_d;
  logic [CountWidth-1:0] count_q, count_d;

  logic                out_valid_q, taken_q, complete_q;
  logic [CostWidth-1:0]  out_cost_q;
  logic [CountWidth-1:0] out_count_q;

  // forest memories
  logic [NW-1:0] parent_mem [NODES];
  logic [SW-1:0] size_mem   [NODES];
  logic [NW-1:0] p_raddr, p_waddr, p_wdata, p_rdata_q;
  logic [NW-1:0] s_raddr, s_waddr;
  logic [SW-1:0] s_wdata, s_rdata_q;
  logic          p_we, s_we;

  logic [CostWidth:0] cost_sum;
  logic [NW-1:0]      a_idx, b_idx;

  assign a_idx = NW'(cmd_q.end_a);
  assign b_idx = NW'(cmd_q.end_b);

  // saturating totals for a taken edge
  assign cost_sum = {1'b0, cost_q} + (CostWidth+1)'(cmd_q.weight);
  assign cost_d   = cost_sum[CostWidth] ? {CostWidth{1'b1}} : cost_sum[CostWidth-1:0];
  assign count_d  = (count_q == {CountWidth{1'b1}}) ? count_q : count_q + 1'b1;

  // memory port control
  always_comb begin
    p_raddr = r_q;
    p_we    = 1'b0;
    p_waddr = x_q;
    p_wdata = r_q;
    s_raddr = ra_q;
    s_we    = 1'b0;
    s_waddr = ra_q;
    s_wdata = sa_q + s_rdata_q;
    unique case (state_q)
      ST_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_q;
        p_wdata = clr_q;
        s_we    = 1'b1;
        s_waddr = clr_q;
        s_wdata = SW'(1);
      end
      ST_CRD:  p_raddr = x_q;
      ST_CCHK: p_we = (x_q != r_q);
      ST_SZB:  s_raddr = r_q;
      ST_SZC: begin
        p_we = 1'b1;
        s_we = 1'b1;
        if (sa_q > s_rdata_q) begin
          p_waddr = r_q;
          p_wdata = ra_q;
          s_waddr = ra_q;
        end else begin
          p_waddr = ra_q;
          p_wdata = r_q;
          s_waddr = r_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (p_we) parent_mem[p_waddr] <= p_wdata;
    p_rdata_q <= parent_mem[p_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) size_mem[s_waddr] <= s_wdata;
    s_rdata_q <= size_mem[s_raddr];
  end

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i && !out_valid_q;
  assign busy_o  = (state_q == ST_CLEAR) && !resume_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      resume_q    <= 1'b0;
      side_q      <= 1'b0;
      cost_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LastIdx) begin
            state_q <= resume_q ? ST_EVAL : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop_o) begin
            cmd_q <= q_cmd_i;
            if (q_cmd_i.restart) begin
              cost_q   <= '0;
              count_q  <= '0;
              clr_q    <= '0;
              resume_q <= 1'b1;
              state_q  <= ST_CLEAR;
            end else begin
              state_q <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          if (cmd_q.ignore || (count_q >= edge_goal_i)) begin
            out_valid_q <= 1'b1;
            taken_q     <= 1'b0;
            out_cost_q  <= cost_q;
            out_count_q <= count_q;
            complete_q  <= (count_q >= edge_goal_i);
            state_q     <= ST_IDLE;
          end else begin
            side_q  <= 1'b0;
            r_q     <= a_idx;
            x_q     <= a_idx;
            state_q <= ST_FRD;
          end
        end
        ST_FRD: state_q <= ST_FCHK;
        ST_FCHK: begin
          if (p_rdata_q == r_q) begin
            state_q <= ST_CRD;
          end else begin
            r_q     <= p_rdata_q;
            state_q <= ST_FRD;
          end
        end
        ST_CRD: state_q <= ST_CCHK;
        ST_CCHK: begin
          if (x_q != r_q) begin
            // point this node at the root and move on
            x_q     <= p_rdata_q;
            state_q <= ST_CRD;
          end else if (!side_q) begin
            ra_q    <= r_q;
            side_q  <= 1'b1;
            r_q     <= b_idx;
            x_q     <= b_idx;
            state_q <= ST_FRD;
          end else if (ra_q == r_q) begin
            out_valid_q <= 1'b1;
            taken_q     <= 1'b0;
            out_cost_q  <= cost_q;
            out_count_q <= count_q;
            complete_q  <= (count_q >= edge_goal_i);
            state_q     <= ST_IDLE;
          end else begin
            state_q <= ST_SZA;
          end
        end
        ST_SZA: state_q <= ST_SZB;
        ST_SZB: begin
          sa_q    <= s_rdata_q;
          state_q <= ST_SZC;
        end
        ST_SZC: begin
          cost_q      <= cost_d;
          count_q     <= count_d;
          out_valid_q <= 1'b1;
          taken_q     <= 1'b1;
          out_cost_q  <= cost_d;
          out_count_q <= count_d;
          complete_q  <= (count_d >= edge_goal_i);
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      if (state_q == ST_CLEAR && clr_q == LastIdx) resume_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, complete_q, out_count_q, out_cost_q, taken_q};

endmodule

### rtl/kruskal_union_find_mst_unit.sv
// ----------------------------------------------------------------------------
// kruskal_union_find_mst_unit
// Streaming Kruskal spanning tree over sorted edges, union-find by size.
// ----------------------------------------------------------------------------
// channel    direction  handshake                       payload
// s_axis     in         s_axis_tvalid / s_axis_tready   end_a, end_b, weight, restart
// m_axis     out        m_axis_tvalid / m_axis_tready   taken, cost, count, complete
// cfg        in         cfg_we_i                        cfg_idx_i, cfg_data_i
//
// an edge is evaluated and then, on each endpoint, walked through the parent
// memory: a root check, the parent hops, a closing compression check and the
// compressed nodes; a union by size follows
// after reset, and on every restart edge, a sweep clears the forest; edges
// are refused during the sweep after reset
// a four-entry queue lets input transactions arrive while the back end walks;
// a held result stalls the back end, and the input once the queue is full
// ----------------------------------------------------------------------------
module kruskal_union_find_mst_unit
  import kum_pkg::*;
#(
  parameter int NODES       = DefNodes,
  parameter int WEIGHT_BITS = DefWeightBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // end_a[9:0], end_b[19:10], weight[35:20], restart[36], zero fill
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // taken[0], total_cost[26:1], edges_taken[37:27], complete[38], zero fill
  output logic [OutDataWidth-1:0] m_axis_tdata,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  logic [CountWidth-1:0] edge_goal_q;
  logic                  skip_en_q;
  logic [NodeBits-1:0]   skip_node_q;

  cmd_t push_cmd, head_cmd;
  logic push, pop, full, empty, busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_goal_q <= GoalReset;
      skip_en_q   <= 1'b0;
      skip_node_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegEdgeGoal:   edge_goal_q <= cfg_data_i[CountWidth-1:0];
        RegSkipEnable: skip_en_q   <= cfg_data_i[0];
        RegSkipNode:   skip_node_q <= cfg_data_i[NodeBits-1:0];
        default: ;
      endcase
    end
  end

  kum_front #(
    .NODES      (NODES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .skip_en_i    (skip_en_q),
    .skip_node_i  (skip_node_q),
    .busy_i       (busy),
    .q_full_i     (full),
    .q_push_o     (push),
    .q_cmd_o      (push_cmd)
  );

  kum_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .full_o (full),
    .empty_o(empty)
  );

  kum_back #(
    .NODES(NODES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .edge_goal_i  (edge_goal_q),
    .q_empty_i    (empty),
    .q_cmd_i      (head_cmd),
    .q_pop_o      (pop),
    .busy_o       (busy),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives sorted edges into the spanning tree unit, predicts every result
// with a union-find forest of its own and checks each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import kum_pkg::*;

  localparam int NumNodes   = 1024;
  localparam int CostMax    = 26'h3FFFFFF;
  localparam int CountMax   = 11'h7FF;
  localparam int WatchLimit = 200000;

  typedef struct packed {
    logic                  complete;
    logic [CountWidth-1:0] edges_taken;
    logic [CostWidth-1:0]  total_cost;
    logic                  taken;
  } mst_result_t;

  // forest predictor and queue of pending results
  class mst_scoreboard;
    int unsigned parent[NumNodes];
    int unsigned tree_size[NumNodes];
    int unsigned cost;
    int unsigned count;
    int unsigned goal;
    bit          skip_en;
    int unsigned skip_at;
    mst_result_t pending[$];
    int          errors;

    function new();
      goal = GoalReset;
      skip_en = 0;
      skip_at = 0;
      errors = 0;
      clear_forest();
    endfunction

    function void clear_forest();
      for (int i = 0; i < NumNodes; i++) begin
        parent[i] = i;
        tree_size[i] = 1;
      end
      cost = 0;
      count = 0;
    endfunction

    function void set_reg(logic [CfgIdxWidth-1:0] idx, int unsigned val);
      case (idx)
        RegEdgeGoal:   goal = val & 11'h7FF;
        RegSkipEnable: skip_en = val[0];
        RegSkipNode:   skip_at = val & 10'h3FF;
        default: ;
      endcase
    endfunction

    function int unsigned root_of(int unsigned x);
      int unsigned r;
      int unsigned nxt;
      r = x;
      while (parent[r] != r) r = parent[r];
      while (x != r) begin
        nxt = parent[x];
        parent[x] = r;
        x = nxt;
      end
      return r;
    endfunction

    // note an accepted edge and queue its expected result
    function void note_edge(logic [9:0] a, logic [9:0] b, logic [15:0] w, logic rs);
      int unsigned ra;
      int unsigned rb;
      mst_result_t res;
      res.taken = 0;
      if (rs) clear_forest();
      if (count < goal && !(skip_en && b == skip_at)) begin
        ra = root_of(a);
        rb = root_of(b);
        if (ra != rb) begin
          if (tree_size[ra] > tree_size[rb]) begin
            parent[rb] = ra;
            tree_size[ra] += tree_size[rb];
          end else begin
            parent[ra] = rb;
            tree_size[rb] += tree_size[ra];
          end
          cost = (cost + w > CostMax) ? CostMax : cost + w;
          if (count < CountMax) count++;
          res.taken = 1;
        end
      end
      res.total_cost = CostWidth'(cost);
      res.edges_taken = CountWidth'(count);
      res.complete = (count >= goal);
      pending.insert(pending.size(), res);
    endfunction

    function void check_result(mst_result_t got);
      mst_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.taken !== exp.taken) begin
        $display("%0t: taken exp %0d got %0d", $time, exp.taken, got.taken);
        errors++;
      end
      if (got.total_cost !== exp.total_cost) begin
        $display("%0t: cost exp %0d got %0d", $time, exp.total_cost, got.total_cost);
        errors++;
      end
      if (got.edges_taken !== exp.edges_taken) begin
        $display("%0t: count exp %0d got %0d", $time, exp.edges_taken, got.edges_taken);
        errors++;
      end
      if (got.complete !== exp.complete) begin
        $display("%0t: complete exp %0d got %0d", $time, exp.complete, got.complete);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i = 0;
  logic                    rst_ni = 0;
  logic                    s_axis_tvalid = 0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_we_i = 0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  mst_scoreboard sb = new();
  bit            steady = 0;
  int unsigned   cur_weight = 0;
  int unsigned   stall_cycles = 0;

  always #4 clk_i = ~clk_i;

  kruskal_union_find_mst_unit dut (.*);

  // result side: random stalls, checking on each transaction
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[38:0]);
    m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 21);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one register write, then the port is left quiet before the task returns
  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, int unsigned val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgDataWidth'(val);
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (NumNodes + 200) @(posedge clk_i);
  endtask

  // one edge transaction with a random idle gap ahead of it
  task automatic send_edge(logic [9:0] a, logic [9:0] b, logic [15:0] w, logic rs);
    while (!steady && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {3'b0, rs, w, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_edge(a, b, w, rs);
  endtask

  // random sorted edge run over nodes 0 to span
  task automatic random_run(int n, int unsigned span, int unsigned step);
    cur_weight = $urandom_range(step);
    send_edge($urandom_range(span), $urandom_range(span), cur_weight, 1);
    for (int i = 1; i < n; i++) begin
      if (cur_weight + step < 65536) cur_weight += $urandom_range(step);
      send_edge($urandom_range(span), $urandom_range(span), cur_weight,
                ($urandom_range(99) < 2));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, self loop, tie, skip, goal
    send_edge(10'd0, 10'd1023, 16'd0, 1);
    send_edge(10'd1023, 10'd0, 16'd1, 0);
    send_edge(10'd5, 10'd5, 16'd2, 0);
    send_edge(10'd2, 10'd3, 16'd3, 0);
    send_edge(10'd3, 10'd0, 16'd65535, 0);
    send_edge(10'd682, 10'd341, 16'd65535, 0);
    drain();
    write_reg(RegEdgeGoal, 0);
    send_edge(10'd1, 10'd2, 16'd7, 1);
    drain();
    write_reg(RegEdgeGoal, 2);
    write_reg(RegSkipEnable, 1);
    write_reg(RegSkipNode, 1023);
    send_edge(10'd1023, 10'd4, 16'd1, 1);
    send_edge(10'd4, 10'd1023, 16'd2, 0);
    send_edge(10'd6, 10'd7, 16'd3, 0);
    send_edge(10'd8, 10'd9, 16'd4, 0);
    drain();

    // random phases over several settings
    write_reg(RegSkipEnable, 0);
    write_reg(RegEdgeGoal, 1024);
    random_run(300, 63, 300);
    drain();
    write_reg(RegEdgeGoal, 20);
    write_reg(RegSkipEnable, 1);
    write_reg(RegSkipNode, 0);
    random_run(300, 31, 3000);
    drain();
    write_reg(RegEdgeGoal, 2047);
    write_reg(RegSkipNode, 1023);
    steady = 1;
    random_run(300, 1023, 200);
    steady = 0;
    drain();
    write_reg(RegSkipEnable, 0);
    write_reg(RegEdgeGoal, 1023);
    // whole-range edges to reach many merges and large costs
    random_run(600, 1023, 200);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### files.f
rtl/kum_pkg.sv
rtl/kum_front.sv
rtl/kum_queue.sv
rtl/kum_back.sv
rtl/kruskal_union_find_mst_unit.sv
tb/tb.sv
